// File: rtl/rdct_pkg.sv
// Shared types and constants for the reload down-counter timer.
// Holds the transaction structs, command and address codes and control bit positions.
// No dependencies.
package rdct_pkg;

  // Command codes carried by an input transaction.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register addresses.
  localparam logic [1:0] ADDR_CTRL    = 2'd0;
  localparam logic [1:0] ADDR_RELOAD  = 2'd1;
  localparam logic [1:0] ADDR_CURRENT = 2'd2;

  // Control register layout.
  localparam int CTRL_WIDTH        = 3;
  localparam int CTRL_ENABLE_BIT   = 0;
  localparam int CTRL_INTEN_BIT    = 1;
  localparam int CTRL_FULLRATE_BIT = 2;
  localparam int FLAG_POS          = 16;

  // Width of the slow-source prescaler.
  localparam int PRESCALE_WIDTH = 3;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  reg_address;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        interrupt_pulse;
    logic        running;
  } out_item_t;

endpackage

// File: rtl/rdct_core.sv
// Timer state and the single-pass update logic for one transaction.
// Depends on rdct_pkg for the transaction structs and codes.
module rdct_core import rdct_pkg::*; #(
  parameter int COUNTER_WIDTH = 24,
  parameter int SLOW_DIVIDE   = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  logic      one_shot,
  input  in_item_t  item,
  output out_item_t result
);

  logic [CTRL_WIDTH-1:0]     ctrl, ctrl_next;
  logic                      flag, flag_next;
  logic [COUNTER_WIDTH-1:0]  reload, reload_next;
  logic [COUNTER_WIDTH-1:0]  current, current_next;
  logic [PRESCALE_WIDTH-1:0] prescale, prescale_next;

  logic [COUNTER_WIDTH-1:0]  current_dec;
  logic [PRESCALE_WIDTH-1:0] prescale_inc;
  logic                      do_count;
  logic                      pulse;
  logic [31:0]               rd;

  assign current_dec  = current - COUNTER_WIDTH'(1);
  assign prescale_inc = prescale + PRESCALE_WIDTH'(1);

  always_comb begin
    ctrl_next     = ctrl;
    flag_next     = flag;
    reload_next   = reload;
    current_next  = current;
    prescale_next = prescale;
    do_count      = 1'b0;
    pulse         = 1'b0;
    rd            = '0;

    case (item.command)
      CMD_TICK: begin
        if (ctrl[CTRL_ENABLE_BIT]) begin
          if (ctrl[CTRL_FULLRATE_BIT]) begin
            do_count = 1'b1;
          end else if ((4'(prescale_inc) >= 4'(SLOW_DIVIDE)) ||
                       (prescale_inc == '0)) begin
            prescale_next = '0;
            do_count      = 1'b1;
          end else begin
            prescale_next = prescale_inc;
          end
        end
      end
      CMD_READ: begin
        case (item.reg_address)
          ADDR_CTRL: begin
            rd        = 32'(ctrl) | (32'(flag) << FLAG_POS);
            flag_next = 1'b0;
          end
          ADDR_RELOAD:  rd = 32'(reload);
          ADDR_CURRENT: rd = 32'(current);
          default:      rd = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_address)
          ADDR_CTRL:   ctrl_next   = item.write_data[CTRL_WIDTH-1:0];
          ADDR_RELOAD: reload_next = item.write_data[COUNTER_WIDTH-1:0];
          ADDR_CURRENT: begin
            current_next = '0;
            flag_next    = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // One count of the down-counter: reload from zero, flag the step to zero.
    if (do_count) begin
      if (current == '0) begin
        current_next = reload;
      end else begin
        current_next = current_dec;
        if (current_dec == '0) begin
          flag_next = 1'b1;
          if (ctrl[CTRL_INTEN_BIT]) begin
            pulse = 1'b1;
            if (one_shot) begin
              ctrl_next[CTRL_ENABLE_BIT] = 1'b0;
              ctrl_next[CTRL_INTEN_BIT]  = 1'b0;
              reload_next                = '0;
              current_next               = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '0;
      flag     <= 1'b0;
      reload   <= '0;
      current  <= '0;
      prescale <= '0;
    end else if (fire) begin
      ctrl     <= ctrl_next;
      flag     <= flag_next;
      reload   <= reload_next;
      current  <= current_next;
      prescale <= prescale_next;
    end
  end

  assign result.read_data       = rd;
  assign result.interrupt_pulse = pulse;
  assign result.running         = ctrl_next[CTRL_ENABLE_BIT];

`ifndef SYNTHESIS
  // A one-shot expiry with a pulse leaves the timer stopped and cleared.
  a_one_shot_stop: assert property (@(posedge clk) disable iff (rst)
    fire && pulse && one_shot |=> !ctrl[CTRL_ENABLE_BIT] && current == '0)
    else $error("one-shot expiry did not stop the timer");

  // A pulse always comes with the count flag set on the next cycle.
  a_pulse_sets_flag: assert property (@(posedge clk) disable iff (rst)
    fire && pulse |=> flag)
    else $error("interrupt pulse without count flag");

  // The prescaler never passes the divide ratio.
  a_prescale_range: assert property (@(posedge clk) disable iff (rst)
    4'(prescale) < 4'(SLOW_DIVIDE))
    else $error("prescaler out of range");
`endif

endmodule

// File: rtl/reload_down_counter_timer_top.sv
// Top level of the reload down-counter timer: handshakes, input and result registers.
// Depends on rdct_pkg and rdct_core.
//
// Usage: every input transaction is a clock tick, a register read or a register write,
// and each one yields exactly one result transaction with the read data, the interrupt
// pulse and the enable state after the transaction.
// The input channel (in_valid, in_stall, in_data) takes a transaction at a clock edge
// where in_valid is high and in_stall is low. The transaction is held in an input
// register; when it advances, the timer state is updated from it and the result is
// loaded into the output register, which raises out_valid. While out_stall is low,
// throughput is one transaction per cycle: the whole update is one short pass through
// the counter decrement and compare between the input and the result register.
// When the receiver raises out_stall, the result register holds its transaction and
// the input register fills; in_stall then rises until the result is taken.
// The one_shot register is written over the cfg channel (cfg_valid, cfg_ready,
// cfg_data), which is always ready; write it only while the block is idle.
// A synchronous reset clears the timer state, the one_shot register and both
// valid flags; no clearing pass follows, so transactions are taken at once.
module reload_down_counter_timer_top import rdct_pkg::*; #(
  parameter int COUNTER_WIDTH = 24,
  parameter int SLOW_DIVIDE   = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  in_item_t  in_reg;
  logic      in_full;
  logic      one_shot;
  logic      advance;
  logic      in_accept;
  out_item_t result;

  // The held transaction moves on whenever the result register is empty or draining.
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_shot <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      one_shot <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg <= in_data;
    end
  end

  rdct_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .SLOW_DIVIDE   (SLOW_DIVIDE)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .one_shot (one_shot),
    .item     (in_reg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // Input is only held back by a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && in_full)
    else $error("input stalled without a stalled result");

  // A processed transaction always shows up as a valid result.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction lost");

  // A taken result with nothing pending leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !in_full |=> !out_valid)
    else $error("result repeated");
`endif

endmodule
